FILE: rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_RANGE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic check;
        logic gcd_step;
        logic divn_start;
        logic divd_start;
        logic div_step;
        logic range;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: products, then gcd and two divisions if num and den are nonzero.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic     out_free,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          res_load
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.den_zero || stat.num_zero)
                    state_next = S_OUT;
                else
                    state_next = S_GCD;
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.divn_start = 1'b1;
                    state_next     = S_DIVN;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIVN:
            begin
                if (stat.div_done)
                begin
                    cmd.divd_start = 1'b1;
                    state_next     = S_DIVD;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_DIVD:
            begin
                if (stat.div_done)
                    state_next = S_RANGE;
                else
                    cmd.div_step = 1'b1;
            end
            S_RANGE:
            begin
                cmd.range  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/rau_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: cross products, Euclid gcd by restoring division, reduction.
// ----------------------------------------------------------------------------
module rau_dp
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] a_num,
    input  wire logic [30:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [30:0] b_den,
    output dp_stat_t         stat,
    output logic [31:0]      res_num,
    output logic [30:0]      res_den,
    output logic [1:0]       status
);

    localparam logic [63:0] LIMIT = 64'd1 << (WORD_BITS - 1);

    logic [1:0]         op_reg;
    logic signed [32:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [65:0] p1_reg, p2_reg;
    logic               neg_reg, nzero_reg;
    logic [63:0]        mag_reg, dmag_reg;
    // gcd pair and divider
    logic [63:0]        x_reg, y_reg;
    logic [63:0]        q_reg, r_reg, dvd_reg, dvs_reg;
    logic [6:0]         cnt_reg;
    logic               dbusy_reg;
    logic               gmode_reg;
    logic [63:0]        g_reg;
    logic [1:0]         sel_reg;   // 0 gcd, 1 num, 2 den
    logic [31:0]        rn_reg;
    logic [30:0]        rd_reg;
    logic [1:0]         st_reg;

    logic signed [32:0] m1a, m1b, m2a, m2b;
    logic signed [65:0] mprod;
    logic signed [66:0] numw;
    logic signed [65:0] denw;
    logic [64:0]        rsh;
    logic [63:0]        rnew;
    logic               rge;

    always_comb
    begin
        m1a = an_reg;
        m1b = bd_reg;
        m2a = bn_reg;
        m2b = ad_reg;
        case (op_reg)
            OP_MUL:  begin m2a = an_reg; m2b = bn_reg; end
            default: ;
        endcase
    end

    // one multiplier for the numerator products, used twice; the denominator product has its own
    assign mprod = cmd.mul1 ? m1a * m1b : m2a * m2b;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  numw = {p1_reg[65], p1_reg} + {p2_reg[65], p2_reg};
            OP_SUB:  numw = {p1_reg[65], p1_reg} - {p2_reg[65], p2_reg};
            OP_MUL:  numw = {p2_reg[65], p2_reg};
            default: numw = {p1_reg[65], p1_reg};
        endcase
    end

    assign rsh  = {r_reg, dvd_reg[63]};
    assign rge  = rsh >= {1'b0, dvs_reg};
    assign rnew = rge ? 64'(rsh - {1'b0, dvs_reg}) : rsh[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.gcd_step && !dbusy_reg && y_reg != '0)
            begin
                dbusy_reg <= 1'b1;
                cnt_reg   <= 7'd64;
            end
            else if (cmd.divn_start || cmd.divd_start)
            begin
                dbusy_reg <= 1'b1;
                cnt_reg   <= 7'd64;
            end
            else if ((cmd.gcd_step || cmd.div_step) && dbusy_reg)
            begin
                if (cnt_reg == 7'd1)
                    dbusy_reg <= 1'b0;
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            an_reg <= {a_num[31], a_num};
            ad_reg <= {2'b00, a_den};
            bn_reg <= {b_num[31], b_num};
            bd_reg <= {2'b00, b_den};
        end
        if (cmd.mul1)
            p1_reg <= mprod;
        if (cmd.mul2)
            p2_reg <= mprod;
        if (cmd.sum)
        begin
            // numerator sign and magnitude
            mag_reg   <= numw[66] ? 64'(-numw) : numw[63:0];
            neg_reg   <= numw[66];
            nzero_reg <= numw == '0;
        end
        if (cmd.check)
        begin
            dmag_reg  <= denw[65] ? 64'(-denw) : denw[63:0];
            neg_reg   <= neg_reg ^ denw[65];
            x_reg     <= mag_reg;
            y_reg     <= denw[65] ? 64'(-denw) : denw[63:0];
            gmode_reg <= 1'b1;
            if (denw == '0)
            begin
                rn_reg <= '0; rd_reg <= '0; st_reg <= ST_DIV0;
            end
            else
            begin
                rn_reg <= '0; rd_reg <= 31'd1; st_reg <= ST_OK;
            end
        end
        if (cmd.gcd_step && !dbusy_reg && y_reg != '0)
        begin
            dvd_reg <= x_reg;
            dvs_reg <= y_reg;
            r_reg   <= '0;
        end
        if (cmd.divn_start)
        begin
            g_reg   <= x_reg;
            dvd_reg <= mag_reg;
            dvs_reg <= x_reg;
            r_reg   <= '0;
            sel_reg <= 2'd1;
        end
        if (cmd.divd_start)
        begin
            mag_reg <= q_reg;
            dvd_reg <= dmag_reg;
            dvs_reg <= g_reg;
            r_reg   <= '0;
            sel_reg <= 2'd2;
        end
        if ((cmd.gcd_step || cmd.div_step) && dbusy_reg)
        begin
            r_reg   <= rnew;
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], rge};
            if (cmd.gcd_step && cnt_reg == 7'd1)
            begin
                x_reg <= y_reg;
                y_reg <= rnew;
            end
        end
        if (cmd.range)
        begin
            if (q_reg > LIMIT - 64'd1 ||
                (neg_reg ? mag_reg > LIMIT : mag_reg > LIMIT - 64'd1))
            begin
                rn_reg <= '0; rd_reg <= '0; st_reg <= ST_OVF;
            end
            else
            begin
                rn_reg <= neg_reg ? 32'(-mag_reg) : mag_reg[31:0];
                rd_reg <= q_reg[30:0];
                st_reg <= ST_OK;
            end
        end
        if (cmd.load)
            sel_reg <= 2'd0;
    end

    // denominator product formed combinationally from registered operands
    always_comb
    begin
        case (op_reg)
            OP_DIV:  denw = ad_reg * bn_reg;
            default: denw = ad_reg * bd_reg;
        endcase
    end

    assign stat = '{den_zero: denw == '0,
                    num_zero: nzero_reg,
                    gcd_done: !dbusy_reg && y_reg == '0 && gmode_reg,
                    div_done: !dbusy_reg && sel_reg != 2'd0};
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign status  = st_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions, reduced by gcd.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis word carries opcode and both operands; m_axis returns one word
//   with the reduced numerator, denominator and status for each input.
//   One item is worked on at a time. A zero or divide-by-zero result
//   skips the gcd and both divisions (products and checks only).
//   Otherwise the block runs the Euclid remainder steps, each a full
//   division on a bit-serial 64-bit divider, then the two divisions by
//   the gcd that reduce the numerator and denominator.
//   The result sits in an output register; a new word is taken as soon as
//   the sequencer is idle, the cycle after the result is loaded, while an
//   earlier result may still wait on m_axis_tready. If the register is
//   still full when a result is ready, the sequencer holds and
//   s_axis_tready stays low. Reset empties the output register and idles
//   the block.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[1:0], a_num[33:2], a_den[64:34], b_num[96:65], b_den[127:97]
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num[31:0], res_den[62:32], status[64:63]
    output logic [71:0]       m_axis_tdata
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        busy, res_load, in_fire;
    logic [31:0] rn;
    logic [30:0] rd;
    logic [1:0]  st;
    logic        ovalid_reg;
    logic [71:0] odata_reg;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!ovalid_reg || m_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .res_load (res_load)
    );

    rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .opcode  (s_axis_tdata[1:0]),
        .a_num   (s_axis_tdata[33:2]),
        .a_den   (s_axis_tdata[64:34]),
        .b_num   (s_axis_tdata[96:65]),
        .b_den   (s_axis_tdata[127:97]),
        .stat    (stat),
        .res_num (rn),
        .res_den (rd),
        .status  (st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            odata_reg <= {7'd0, st, rd, rn};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule
`default_nettype wire
